>>> rtl/tcpa_pkg.sv
// package for the two-class pool allocator: sizes, widths, command and status codes
// no dependencies; imported by two_class_pool_allocator

package tcpa_pkg;

	localparam int POOL_BYTES    = 65536;
	localparam int SMALL_BYTES   = 64;
	localparam int LARGE_BYTES   = 256;
	localparam int GRANULE_BYTES = 8;

	localparam int OFFSET_SPACE = 65536;
	localparam int OFF_W        = 16;
	localparam int HEAD_W       = OFF_W + 1;
	localparam int CAP_W        = 17;
	localparam int SUM_W        = CAP_W + 1;
	localparam int GRAN_SHIFT   = $clog2(GRANULE_BYTES);
	localparam int LINK_DEPTH   = OFFSET_SPACE / GRANULE_BYTES;
	localparam int LINK_AW      = $clog2(LINK_DEPTH);
	localparam int BUMP_MAX     = (POOL_BYTES < OFFSET_SPACE) ? POOL_BYTES : OFFSET_SPACE;
	localparam int CAP_RESET    = 65536;

	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 8;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_USER_W = 8;

	typedef enum logic [1:0] {
		CMD_ALLOC_SMALL = 2'd0,
		CMD_ALLOC_LARGE = 2'd1,
		CMD_FREE_SMALL  = 2'd2,
		CMD_FREE_LARGE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_OOM       = 2'd1,
		STAT_NULL_FREE = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// head or link: bit 16 valid, bits 15..0 entry offset
	function automatic logic [LINK_AW-1:0] granule_of(input logic [OFF_W-1:0] off);
		logic [OFF_W-1:0] g;
		g = off >> GRAN_SHIFT;
		return g[LINK_AW-1:0];
	endfunction

endpackage

>>> rtl/tcpa_ram.sv
// generic simple dual-port ram with registered read data
// no dependencies; holds the link store of the pool allocator

module tcpa_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/two_class_pool_allocator.sv
// two-class pool allocator top level: request register, link store, result register
// depends on tcpa_pkg and tcpa_ram
//
// usage:
//   s_* channel takes one request: s_tuser holds cmd (0 alloc small, 1 alloc large,
//   2 free small, 3 free large) and free_present; s_tdata holds free_offset.
//   m_* channel returns one result per request: entry_offset and status.
//   cfg_* channel writes pool_capacity; always ready, write it only while idle.
// timing:
//   in the accept cycle the link store is read at the granule behind the class's list
//   head; in the next cycle (exec) the registered read data, heads and used count
//   settle the result, which is then loaded into the result register.
//   no new request is taken while one is executing; the result is valid in the
//   cycle after exec.
// stalls:
//   a result held by a stalled receiver blocks only the next request's accept
//   until it is taken; a request is accepted in the same cycle the old result leaves.
// reset:
//   both free lists empty, used count zero, capacity 65536; the link store is not
//   cleared, and its read data is only used behind entries that were written.

module two_class_pool_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tcpa_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] free_offset
	input  logic [tcpa_pkg::IN_USER_W-1:0]   s_tuser,   // [1:0] cmd, [2] free_present
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tcpa_pkg::OUT_DATA_W-1:0]  m_tdata,   // [15:0] entry_offset
	output logic [tcpa_pkg::OUT_USER_W-1:0]  m_tuser,   // [1:0] status
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tcpa_pkg::CAP_W-1:0]       cfg_data   // pool_capacity
);

	import tcpa_pkg::*;

	state_t state_q, state_d;
	logic   accept, exec_en;

	cmd_t             cmd_s1;
	logic [OFF_W-1:0] off_s1;
	logic             present_s1;

	logic [CAP_W-1:0]  cap_q;
	logic [CAP_W-1:0]  used_q, used_d;
	logic [HEAD_W-1:0] small_head_q, large_head_q;
	logic [HEAD_W-1:0] head_in, head_cur, head_new;
	logic              head_upd;

	logic [HEAD_W-1:0]  link_rdata;
	logic               link_we;
	logic [LINK_AW-1:0] link_raddr, link_waddr;

	logic [CAP_W-1:0] limit;
	logic [SUM_W-1:0] bump_next;
	logic [SUM_W-1:0] class_size;

	logic [OFF_W-1:0] entry_d;
	status_t          status_d;

	logic             m_valid_q;
	logic [OFF_W-1:0] entry_q;
	status_t          status_q;

	// fsm: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// fsm: outputs
	always_comb begin
		s_tready = 1'b0;
		exec_en  = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = !m_valid_q || m_tready;
			ST_EXEC: exec_en  = 1'b1;
			default: s_tready = 1'b0;
		endcase
	end

	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd_t'(s_tuser[1:0]);
			off_s1     <= s_tdata[OFF_W-1:0];
			present_s1 <= s_tuser[2];
		end
	end

	// read the link behind the head of the incoming request's class
	assign head_in    = s_tuser[0] ? large_head_q : small_head_q;
	assign link_raddr = granule_of(head_in[OFF_W-1:0]);

	tcpa_ram #(
		.WIDTH(HEAD_W),
		.DEPTH(LINK_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (head_cur),
		.re    (accept),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	assign head_cur   = cmd_s1[0] ? large_head_q : small_head_q;
	assign limit      = (cap_q > CAP_W'(BUMP_MAX)) ? CAP_W'(BUMP_MAX) : cap_q;
	assign class_size = cmd_s1[0] ? SUM_W'(LARGE_BYTES) : SUM_W'(SMALL_BYTES);
	assign bump_next  = {1'b0, used_q} + class_size;
	assign link_waddr = granule_of(off_s1);

	always_comb begin
		entry_d  = '0;
		status_d = STAT_DONE;
		used_d   = used_q;
		head_new = head_cur;
		head_upd = 1'b0;
		link_we  = 1'b0;
		unique case (cmd_s1)
			CMD_ALLOC_SMALL, CMD_ALLOC_LARGE: begin
				if (head_cur[OFF_W]) begin
					entry_d  = head_cur[OFF_W-1:0];
					head_new = link_rdata;
					head_upd = 1'b1;
				end else if (bump_next > {1'b0, limit}) begin
					status_d = STAT_OOM;
				end else begin
					entry_d = used_q[OFF_W-1:0];
					used_d  = bump_next[CAP_W-1:0];
				end
			end
			CMD_FREE_SMALL, CMD_FREE_LARGE: begin
				if (!present_s1) begin
					status_d = STAT_NULL_FREE;
				end else begin
					link_we  = exec_en;
					head_new = {1'b1, off_s1};
					head_upd = 1'b1;
				end
			end
			default: status_d = STAT_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_W'(CAP_RESET);
			used_q       <= '0;
			small_head_q <= '0;
			large_head_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (exec_en) begin
				used_q <= used_d;
				if (head_upd && cmd_s1[0]) begin
					large_head_q <= head_new;
				end
				if (head_upd && !cmd_s1[0]) begin
					small_head_q <= head_new;
				end
			end
		end
	end

	// result register; free whenever a request executes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (exec_en) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			entry_q  <= entry_d;
			status_q <= status_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_W'(entry_q);
	assign m_tuser  = OUT_USER_W'(status_q);

endmodule
